// ===== design/adu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adu_pkg: shared types, widths and helpers
// Widths of the fixed-point datapath, function codes and the pipeline record
// that follows each word through the activation and derivative unit.
// ----------------------------------------------------------------------------
package adu_pkg;

    // Number of series terms and stages of each restoring divider.
    localparam int EXP_TERMS  = 64;
    localparam int QW         = 41;
    localparam int DIV_STAGES = QW;
    localparam int DEN_W      = 53;
    localparam int TERM_W     = 50;
    localparam int SUM_W      = 53;
    localparam int PROD_W     = 64;
    localparam int FRAC_SH    = 40;

    // Division of a series product by n uses a rounded-up reciprocal of n.
    // The product shifted down by 12 stays below 2^52, so 58 fraction bits
    // give the exact floor for every n up to the number of terms.
    localparam int Y_W        = PROD_W - 12;
    localparam int YL_W       = 26;
    localparam int RECIP_SH   = 58;
    localparam int RECIP_W    = 59;
    localparam int RL_W       = 29;
    localparam int PP_W       = (Y_W - YL_W) + (RECIP_W - RL_W);
    localparam int QP_W       = Y_W + RECIP_W;

    // Squares of Q.40 values are split into a 20-bit upper and 21-bit lower half.
    localparam int SQ_LO      = 21;
    localparam int SQ_HH_W    = 2 * (QW - SQ_LO);
    localparam int SQ_LL_W    = 2 * SQ_LO;

    // Activation function codes held in the selector register.
    typedef enum logic [2:0] {
        FN_IDENTITY = 3'd0,
        FN_LOGISTIC = 3'd1,
        FN_TANH     = 3'd2,
        FN_RELU     = 3'd3,
        FN_EXP      = 3'd4
    } t_func;

    // Record carried alongside each word down the pipeline.
    typedef struct packed {
        logic signed [15:0] x;
        logic [2:0]         func;
        logic [SUM_W-1:0]   p;
        logic [QW-1:0]      m;
    } t_side;

    // Magnitude of a Q4.12 sample; the most negative code maps to 32768.
    function automatic logic [15:0] abs_x(input logic signed [15:0] x);
        logic [15:0] v;
        v = x;
        return x[15] ? 16'(~v + 16'd1) : v;
    endfunction

    // Q.40 to Q16.16 with round half up.
    function automatic logic [29:0] round_q16(input logic [53:0] v);
        return 30'((v + 54'(1) * 54'h80_0000) >> 24);
    endfunction

    // Sum of the partial products of a squared Q.40 value, scaled back to Q.40.
    function automatic logic [QW-1:0] sq_q40(input logic [SQ_HH_W-1:0] hh,
                                            input logic [QW-1:0]      hl,
                                            input logic [SQ_LL_W-1:0] ll);
        logic [2*QW-1:0] s;
        s = ((2*QW)'(hh) << (2*SQ_LO)) + ((2*QW)'(hl) << (SQ_LO+1)) + (2*QW)'(ll);
        return QW'(s >> FRAC_SH);
    endfunction

endpackage
`default_nettype wire

// ===== design/adu_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adu interfaces: valid/ready channels
// Sample input, result output and selector write channels of the unit.
// ----------------------------------------------------------------------------

// Input channel: one Q4.12 sample per word.
interface adu_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_in;
    modport source (output valid, output x_in, input ready);
    modport sink   (input valid, input x_in, output ready);
endinterface

// Output channel: activation value and derivative per word.
interface adu_out_if;
    logic               valid;
    logic               ready;
    logic signed [28:0] act_value;
    logic [27:0]        act_deriv;
    modport source (output valid, output act_value, output act_deriv, input ready);
    modport sink   (input valid, input act_value, input act_deriv, output ready);
endinterface

// Configuration channel: function selector write.
interface adu_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] func_select;
    modport source (output valid, output func_select, input ready);
    modport sink   (input valid, input func_select, output ready);
endinterface
`default_nettype wire

// ===== design/adu_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adu_div: pipelined restoring divider
// Computes floor(num * 2^40 / den) for num <= den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module adu_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [adu_pkg::QW-1:0]      i_num,
    input  wire logic [adu_pkg::DEN_W-1:0]   i_den,
    output logic      [adu_pkg::QW-1:0]      o_quo
);

    logic [adu_pkg::DEN_W-1:0] r_rem [0:adu_pkg::DIV_STAGES-1];
    logic [adu_pkg::DEN_W-1:0] r_den [0:adu_pkg::DIV_STAGES-1];
    logic [adu_pkg::QW-1:0]    r_quo [0:adu_pkg::DIV_STAGES-1];

    logic [adu_pkg::DEN_W-1:0] n_rem0;
    logic [adu_pkg::QW-1:0]    n_quo0;
    logic                      w_ge0;

    // First stage settles the integer bit of the quotient.
    always_comb begin
        w_ge0  = adu_pkg::DEN_W'(i_num) >= i_den;
        n_rem0 = w_ge0 ? adu_pkg::DEN_W'(i_num) - i_den : adu_pkg::DEN_W'(i_num);
        n_quo0 = '0;
        n_quo0[adu_pkg::QW-1] = w_ge0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem0;
            r_den[0] <= i_den;
            r_quo[0] <= n_quo0;
        end
    end

    // Each further stage shifts the remainder and tries one subtraction.
    for (genvar i = 1; i < adu_pkg::DIV_STAGES; i++) begin : g_stage
        logic [adu_pkg::DEN_W:0]   w_r2;
        logic                      w_ge;
        logic [adu_pkg::DEN_W-1:0] n_rem;
        logic [adu_pkg::QW-1:0]    n_quo;

        always_comb begin
            w_r2  = {r_rem[i-1], 1'b0};
            w_ge  = w_r2 >= {1'b0, r_den[i-1]};
            n_rem = w_ge ? adu_pkg::DEN_W'(w_r2 - {1'b0, r_den[i-1]})
                         : adu_pkg::DEN_W'(w_r2);
            n_quo = r_quo[i-1];
            n_quo[adu_pkg::QW-1-i] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= n_rem;
                r_den[i] <= r_den[i-1];
                r_quo[i] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[adu_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== design/activation_and_derivative_unit_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// activation_and_derivative_unit_core: activation value and derivative
// Throughput: one word per cycle; a stall at the output freezes every stage.
// The series stages for e^|x| (three per term), two 41-stage dividers in
// series and the split squares set the depth. Reset clears all valid bits
// and sets the selector to logistic.
// ----------------------------------------------------------------------------
module activation_and_derivative_unit_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    adu_in_if.sink    i_data,
    adu_out_if.source o_result,
    adu_cfg_if.sink   i_cfg
);

    localparam int NT = adu_pkg::EXP_TERMS;
    localparam int ND = adu_pkg::DIV_STAGES;
    localparam logic [adu_pkg::QW-1:0] ONE_Q40 = adu_pkg::QW'(1) << adu_pkg::FRAC_SH;

    logic w_adv;
    logic [2:0] r_func;

    // Pipeline advances unless a finished word is held at the output.
    assign w_adv        = !o_result.valid || o_result.ready;
    assign i_data.ready = w_adv;
    assign i_cfg.ready  = 1'b1;

    // Function selector register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func <= adu_pkg::FN_LOGISTIC;
        end else if (i_cfg.valid) begin
            r_func <= i_cfg.func_select;
        end
    end

    // Series levels: level 0 is the input register.
    logic                       r_tv   [0:NT];
    logic [adu_pkg::TERM_W-1:0] r_term [0:NT];
    logic [adu_pkg::SUM_W-1:0]  r_sum  [0:NT];
    adu_pkg::t_side             r_ts   [0:NT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv[0] <= 1'b0;
        end else if (w_adv) begin
            r_tv[0] <= i_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_term[0]    <= adu_pkg::TERM_W'(ONE_Q40);
            r_sum[0]     <= adu_pkg::SUM_W'(ONE_Q40);
            r_ts[0].x    <= i_data.x_in;
            r_ts[0].func <= r_func;
            r_ts[0].p    <= '0;
            r_ts[0].m    <= '0;
        end
    end

    // Term n: multiply by |X|, then form the reciprocal partial products,
    // then add them up and accumulate the new term.
    for (genvar k = 1; k <= NT; k++) begin : g_term
        localparam logic [adu_pkg::RECIP_W-1:0] RECIP =
            adu_pkg::RECIP_W'(((64'd1 << adu_pkg::RECIP_SH) + 64'(k) - 64'd1) / 64'(k));
        localparam logic [adu_pkg::RECIP_W-adu_pkg::RL_W-1:0] RECIP_H =
            RECIP[adu_pkg::RECIP_W-1:adu_pkg::RL_W];
        localparam logic [adu_pkg::RL_W-1:0] RECIP_L = RECIP[adu_pkg::RL_W-1:0];

        logic                       r_pv;
        logic [adu_pkg::PROD_W-1:0] r_prod;
        logic [adu_pkg::SUM_W-1:0]  r_psum;
        adu_pkg::t_side             r_ps;
        logic                       r_qv;
        logic [adu_pkg::PP_W-1:0]   r_pp_hh;
        logic [adu_pkg::PP_W-1:0]   r_pp_hl;
        logic [adu_pkg::PP_W-1:0]   r_pp_lh;
        logic [adu_pkg::PP_W-1:0]   r_pp_ll;
        logic [adu_pkg::SUM_W-1:0]  r_qsum;
        adu_pkg::t_side             r_qs;
        logic [adu_pkg::Y_W-1:0]    w_y;
        logic [adu_pkg::QP_W-1:0]   w_q;
        logic [adu_pkg::TERM_W-1:0] n_term;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv    <= 1'b0;
                r_qv    <= 1'b0;
                r_tv[k] <= 1'b0;
            end else if (w_adv) begin
                r_pv    <= r_tv[k-1];
                r_qv    <= r_pv;
                r_tv[k] <= r_qv;
            end
        end

        always_comb begin
            w_y    = r_prod[adu_pkg::PROD_W-1:12];
            w_q    = (adu_pkg::QP_W'(r_pp_hh) << (adu_pkg::YL_W + adu_pkg::RL_W))
                   + (adu_pkg::QP_W'(r_pp_hl) << adu_pkg::YL_W)
                   + (adu_pkg::QP_W'(r_pp_lh) << adu_pkg::RL_W)
                   + adu_pkg::QP_W'(r_pp_ll);
            n_term = adu_pkg::TERM_W'(w_q >> adu_pkg::RECIP_SH);
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_prod    <= adu_pkg::PROD_W'(r_term[k-1])
                           * adu_pkg::PROD_W'(adu_pkg::abs_x(r_ts[k-1].x));
                r_psum    <= r_sum[k-1];
                r_ps      <= r_ts[k-1];
                r_pp_hh   <= adu_pkg::PP_W'(w_y[adu_pkg::Y_W-1:adu_pkg::YL_W])
                           * adu_pkg::PP_W'(RECIP_H);
                r_pp_hl   <= adu_pkg::PP_W'(w_y[adu_pkg::Y_W-1:adu_pkg::YL_W])
                           * adu_pkg::PP_W'(RECIP_L);
                r_pp_lh   <= adu_pkg::PP_W'(w_y[adu_pkg::YL_W-1:0])
                           * adu_pkg::PP_W'(RECIP_H);
                r_pp_ll   <= adu_pkg::PP_W'(w_y[adu_pkg::YL_W-1:0])
                           * adu_pkg::PP_W'(RECIP_L);
                r_qsum    <= r_psum;
                r_qs      <= r_ps;
                r_term[k] <= n_term;
                r_sum[k]  <= r_qsum + adu_pkg::SUM_W'(n_term);
                r_ts[k]   <= r_qs;
            end
        end
    end

    // First divider: m = e^-|x| in Q.40.
    logic [adu_pkg::QW-1:0] w_m;
    logic                   r_dv [1:ND];
    adu_pkg::t_side         r_ds [1:ND];
    adu_pkg::t_side         w_ds0;

    always_comb begin
        w_ds0   = r_ts[NT];
        w_ds0.p = r_sum[NT];
    end

    adu_div u_div_m (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (ONE_Q40),
        .i_den (r_sum[NT]),
        .o_quo (w_m)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[1] <= 1'b0;
        end else if (w_adv) begin
            r_dv[1] <= r_tv[NT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ds[1] <= w_ds0;
        end
    end

    for (genvar i = 2; i <= ND; i++) begin : g_dline
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[i] <= 1'b0;
            end else if (w_adv) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ds[i] <= r_ds[i-1];
            end
        end
    end

    // Square of m: e^-2|x| in Q.40, partial products first, then their sum.
    logic                        r_mv;
    adu_pkg::t_side              r_ms;
    adu_pkg::t_side              w_ms;
    logic [adu_pkg::SQ_HH_W-1:0] r_msq_hh;
    logic [adu_pkg::QW-1:0]      r_msq_hl;
    logic [adu_pkg::SQ_LL_W-1:0] r_msq_ll;
    logic                        r_nv;
    adu_pkg::t_side              r_ns;
    logic [adu_pkg::QW-1:0]      r_m2;

    always_comb begin
        w_ms   = r_ds[ND];
        w_ms.m = w_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_nv <= 1'b0;
        end else if (w_adv) begin
            r_mv <= r_dv[ND];
            r_nv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ms     <= w_ms;
            r_msq_hh <= adu_pkg::SQ_HH_W'(w_m[adu_pkg::QW-1:adu_pkg::SQ_LO])
                      * adu_pkg::SQ_HH_W'(w_m[adu_pkg::QW-1:adu_pkg::SQ_LO]);
            r_msq_hl <= adu_pkg::QW'(w_m[adu_pkg::QW-1:adu_pkg::SQ_LO])
                      * adu_pkg::QW'(w_m[adu_pkg::SQ_LO-1:0]);
            r_msq_ll <= adu_pkg::SQ_LL_W'(w_m[adu_pkg::SQ_LO-1:0])
                      * adu_pkg::SQ_LL_W'(w_m[adu_pkg::SQ_LO-1:0]);
            r_ns     <= r_ms;
            r_m2     <= adu_pkg::sq_q40(r_msq_hh, r_msq_hl, r_msq_ll);
        end
    end

    // Second pair of dividers: logistic(|x|) and tanh(|x|).
    logic [adu_pkg::QW-1:0] w_c;
    logic [adu_pkg::QW-1:0] w_t;
    logic                   r_cv [1:ND];
    adu_pkg::t_side         r_cs [1:ND];

    adu_div u_div_c (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (ONE_Q40),
        .i_den (adu_pkg::DEN_W'(ONE_Q40) + adu_pkg::DEN_W'(r_ns.m)),
        .o_quo (w_c)
    );

    adu_div u_div_t (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (ONE_Q40 - r_m2),
        .i_den (adu_pkg::DEN_W'(ONE_Q40) + adu_pkg::DEN_W'(r_m2)),
        .o_quo (w_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[1] <= 1'b0;
        end else if (w_adv) begin
            r_cv[1] <= r_nv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cs[1] <= r_ns;
        end
    end

    for (genvar i = 2; i <= ND; i++) begin : g_cline
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i] <= 1'b0;
            end else if (w_adv) begin
                r_cv[i] <= r_cv[i-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_cs[i] <= r_cs[i-1];
            end
        end
    end

    // Products for the derivatives: t^2 in two steps and c32 * (2^32 - c32).
    logic                        r_fv;
    adu_pkg::t_side              r_fs;
    logic [adu_pkg::QW-1:0]      r_c;
    logic [adu_pkg::QW-1:0]      r_t;
    logic [adu_pkg::SQ_HH_W-1:0] r_tsq_hh;
    logic [adu_pkg::QW-1:0]      r_tsq_hl;
    logic [adu_pkg::SQ_LL_W-1:0] r_tsq_ll;
    logic [65:0]                 r_lprod;
    logic [32:0]                 w_c32;
    logic                        r_gv;
    adu_pkg::t_side              r_gs;
    logic [adu_pkg::QW-1:0]      r_gc;
    logic [adu_pkg::QW-1:0]      r_gt;
    logic [adu_pkg::QW-1:0]      r_tt;
    logic [65:0]                 r_glprod;

    assign w_c32 = 33'((42'(w_c) + 42'd128) >> 8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_gv <= 1'b0;
        end else if (w_adv) begin
            r_fv <= r_cv[ND];
            r_gv <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fs     <= r_cs[ND];
            r_c      <= w_c;
            r_t      <= w_t;
            r_tsq_hh <= adu_pkg::SQ_HH_W'(w_t[adu_pkg::QW-1:adu_pkg::SQ_LO])
                      * adu_pkg::SQ_HH_W'(w_t[adu_pkg::QW-1:adu_pkg::SQ_LO]);
            r_tsq_hl <= adu_pkg::QW'(w_t[adu_pkg::QW-1:adu_pkg::SQ_LO])
                      * adu_pkg::QW'(w_t[adu_pkg::SQ_LO-1:0]);
            r_tsq_ll <= adu_pkg::SQ_LL_W'(w_t[adu_pkg::SQ_LO-1:0])
                      * adu_pkg::SQ_LL_W'(w_t[adu_pkg::SQ_LO-1:0]);
            r_lprod  <= 66'(w_c32) * 66'((33'd1 << 32) - w_c32);
            r_gs     <= r_fs;
            r_gc     <= r_c;
            r_gt     <= r_t;
            r_tt     <= adu_pkg::sq_q40(r_tsq_hh, r_tsq_hl, r_tsq_ll);
            r_glprod <= r_lprod;
        end
    end

    // Final selection per function.
    logic               w_neg;
    logic signed [29:0] w_lin;
    logic [29:0]        w_sq;
    logic [29:0]        w_tq;
    logic [29:0]        w_e;
    logic [29:0]        w_tder;
    logic [29:0]        w_lder;
    logic signed [29:0] n_val;
    logic [29:0]        n_der;
    logic               r_out_valid;
    logic signed [28:0] r_out_value;
    logic [27:0]        r_out_deriv;

    always_comb begin
        w_neg  = r_gs.x[15];
        w_lin  = 30'(r_gs.x) <<< 4;
        w_sq   = adu_pkg::round_q16(54'(r_gc));
        w_tq   = adu_pkg::round_q16(54'(r_gt));
        w_e    = w_neg ? adu_pkg::round_q16(54'(r_gs.m)) : adu_pkg::round_q16(54'(r_gs.p));
        w_tder = adu_pkg::round_q16(54'(ONE_Q40 - r_tt));
        w_lder = 30'((67'(r_glprod) + (67'd1 << 47)) >> 48);
        unique case (r_gs.func)
            adu_pkg::FN_IDENTITY: begin
                n_val = w_lin;
                n_der = 30'd65536;
            end
            adu_pkg::FN_TANH: begin
                n_val = w_neg ? -$signed(w_tq) : $signed(w_tq);
                n_der = w_tder;
            end
            adu_pkg::FN_RELU: begin
                n_val = w_neg ? 30'sd0 : w_lin;
                n_der = w_neg ? 30'd0 : 30'd65536;
            end
            adu_pkg::FN_EXP: begin
                n_val = $signed(w_e) - 30'sd65536;
                n_der = w_e;
            end
            default: begin
                n_val = w_neg ? 30'sd65536 - $signed(w_sq) : $signed(w_sq);
                n_der = w_lder;
            end
        endcase
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_gv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_value <= n_val[28:0];
            r_out_deriv <= n_der[27:0];
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.act_value = r_out_value;
    assign o_result.act_deriv = r_out_deriv;

endmodule
`default_nettype wire

// ===== design/adu_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adu_checker: port-level checks
// Watches the channels of the unit for reset, stall and flow-control rules.
// ----------------------------------------------------------------------------
module adu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [28:0] i_act_value,
    input wire logic [27:0] i_act_deriv,
    input wire logic        i_cfg_ready
);

    // No result word is shown in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

    // A stalled result word keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_act_value) && $stable(i_act_deriv))
        else $error("stalled result word changed");

    // Input is taken whenever the output is not stalled.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && !i_out_ready) |-> i_in_ready)
        else $error("input refused without an output stall");

    // The selector write channel never back-pressures.
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind activation_and_derivative_unit_core adu_checker u_adu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_data.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_act_value (o_result.act_value),
    .i_act_deriv (o_result.act_deriv),
    .i_cfg_ready (i_cfg.ready)
);
`default_nettype wire

// ===== dv/adu_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// adu_scoreboard: result predictor and scoreboard for the activation unit
// Watches the sample, result and selector channels. For each accepted sample
// it works out the activation value and derivative in fixed point, queues
// them and compares every result word with the oldest queued expectation.
// ----------------------------------------------------------------------------
module adu_scoreboard (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    adu_in_if         i_data,
    adu_out_if        i_result,
    adu_cfg_if        i_cfg,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    typedef struct {
        logic signed [28:0] act_value;
        logic [27:0]        act_deriv;
    } t_act_word;

    localparam logic [127:0] ONE_Q40 = 128'd1 << 40;

    t_act_word  act_expected_q[$];
    logic [2:0] func_sel;

    // Q.40 to Q16.16, rounding half up.
    function automatic logic [127:0] q40_to_q16(input logic [127:0] v);
        return (v + (128'd1 << 23)) >> 24;
    endfunction

    // Activation value and derivative of one Q4.12 sample.
    function automatic t_act_word predict_act(input logic [2:0] sel,
                                              input logic signed [15:0] x);
        t_act_word   w;
        int          xi;
        logic        neg;
        logic [127:0] mag, term, ex, em, em2, lg, lg32, th, th2;
        logic signed [63:0] lin, val, der, tq;
        xi   = x;
        neg  = xi < 0;
        mag  = neg ? 128'(-xi) : 128'(xi);
        lin  = 64'(xi) * 16;
        // e^|x| as a Taylor series, stopping at the first zero term.
        term = ONE_Q40;
        ex   = ONE_Q40;
        for (int n = 1; n <= 64; n++) begin
            term = term * mag / (128'd4096 * n);
            if (term == 0) break;
            ex = ex + term;
        end
        em   = (ONE_Q40 << 40) / ex;
        em2  = (em * em) >> 40;
        lg   = (ONE_Q40 << 40) / (ONE_Q40 + em);
        th   = ((ONE_Q40 - em2) << 40) / (ONE_Q40 + em2);
        th2  = (th * th) >> 40;
        case (sel)
            adu_pkg::FN_IDENTITY: begin
                val = lin;
                der = 65536;
            end
            adu_pkg::FN_TANH: begin
                tq  = 64'(q40_to_q16(th));
                val = neg ? -tq : tq;
                der = 64'(q40_to_q16(ONE_Q40 - th2));
            end
            adu_pkg::FN_RELU: begin
                val = neg ? 0 : lin;
                der = neg ? 0 : 65536;
            end
            adu_pkg::FN_EXP: begin
                der = 64'(q40_to_q16(neg ? em : ex));
                val = der - 65536;
            end
            default: begin
                // Logistic; unknown selector codes fall back to it as well.
                lg32 = (lg + 128) >> 8;
                tq   = 64'(q40_to_q16(lg));
                val  = neg ? 65536 - tq : tq;
                der  = 64'((lg32 * ((128'd1 << 32) - lg32) + (128'd1 << 47)) >> 48);
            end
        endcase
        w.act_value = val[28:0];
        w.act_deriv = der[27:0];
        return w;
    endfunction

    assign o_pending = act_expected_q.size();

    // Track the selector, queue predictions and compare result words.
    always @(posedge i_clk) begin
        t_act_word exp_w;
        if (!i_rst_n) begin
            func_sel     <= adu_pkg::FN_LOGISTIC;
            o_fail_count <= 0;
            o_checked    <= 0;
            act_expected_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                func_sel <= i_cfg.func_select;
            if (i_data.valid && i_data.ready)
                act_expected_q.push_back(predict_act(func_sel, i_data.x_in));
            if (i_result.valid && i_result.ready) begin
                if (act_expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result word with nothing expected: value %0d deriv %0d",
                                 $realtime, i_result.act_value, i_result.act_deriv);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = act_expected_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (exp_w.act_value !== i_result.act_value ||
                        exp_w.act_deriv !== i_result.act_deriv) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch: expected value %0d deriv %0d, got %0d %0d",
                                     $realtime, exp_w.act_value, exp_w.act_deriv,
                                     i_result.act_value, i_result.act_deriv);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: activation and derivative unit
// Steps through every selector code, extremes first, with directed samples
// and random ones under random gaps on the sample side and random stalls on
// the result side. The scoreboard predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY_WAIT = 240;
    localparam int CYCLE_LIMIT  = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, checked, phases;
    int   cycles = 0;

    adu_in_if  data_ch ();
    adu_out_if result_ch ();
    adu_cfg_if cfg_ch ();

    activation_and_derivative_unit_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (data_ch),
        .o_result(result_ch),
        .i_cfg   (cfg_ch)
    );

    adu_scoreboard u_scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (data_ch),
        .i_result    (result_ch),
        .i_cfg       (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Result side stalls; some stretches run with ready held high.
    initial begin
        int stall;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(7) == 0) begin
                stall = gap_len();
                if (stall > 0) begin
                    result_ch.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            result_ch.ready <= 1'b1;
            if ($urandom_range(15) == 0) repeat ($urandom_range(20, 60)) @(negedge i_clk);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one sample word and hold it until accepted.
    task automatic send_sample(input logic signed [15:0] x);
        int gap;
        @(negedge i_clk);
        data_ch.valid <= 1'b1;
        data_ch.x_in  <= x;
        do @(posedge i_clk); while (!data_ch.ready);
        gap = gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            data_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drain the pipeline before the selector changes.
    task automatic wait_idle();
        @(negedge i_clk);
        data_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY_WAIT) @(negedge i_clk);
    endtask

    task automatic write_select(input logic [2:0] sel);
        @(negedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.func_select <= sel;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One phase: directed extremes, then random samples.
    task automatic run_phase(input int n_random);
        logic signed [15:0] directed [12] = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1,
            16'sd1, 16'sd4096, -16'sd4096, 16'sd8192, -16'sd12288, 16'sh4000,
            16'shC000, 16'sh5555};
        int r;
        foreach (directed[i]) send_sample(directed[i]);
        for (int i = 0; i < n_random; i++) begin
            r = $urandom_range(3);
            if (r == 0) send_sample(16'($urandom_range(511)) - 16'sd256);
            else if (r == 1) send_sample(16'($urandom_range(16383)) - 16'sd8192);
            else send_sample(16'($urandom));
        end
        phases++;
    endtask

    initial begin
        // Codes five to seven have no name and must behave as logistic.
        logic [2:0] sel_order [11] = '{adu_pkg::FN_IDENTITY, adu_pkg::FN_TANH,
                                       adu_pkg::FN_RELU, adu_pkg::FN_EXP, 3'd5, 3'd6,
                                       3'd7, adu_pkg::FN_EXP, adu_pkg::FN_IDENTITY,
                                       adu_pkg::FN_TANH, adu_pkg::FN_LOGISTIC};
        phases             = 0;
        data_ch.valid      = 1'b0;
        data_ch.x_in       = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.func_select = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        // First phase runs on the selector's reset value.
        run_phase(90);
        foreach (sel_order[i]) begin
            wait_idle();
            write_select(sel_order[i]);
            run_phase(90);
        end
        wait_idle();
        $display("Ran %0d selector phases, all eight codes included; %0d words checked.",
                 phases, checked);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
design/adu_pkg.sv
design/adu_if.sv
design/adu_div.sv
design/activation_and_derivative_unit_core.sv
design/adu_checker.sv
dv/adu_checker.sv
dv/testbench.sv
